### src/ttcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcc_pkg
// Shared constants and types for the text console cursor control block.
// ----------------------------------------------------------------------------
package ttcc_pkg;

  localparam int ROWS          = 25;
  localparam int COLS          = 80;
  localparam int KEEP_TOP_ROWS = 4;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int GLYPH_W = 8;
  localparam int CHAR_W  = 8;

  localparam int MAX_CMDS = 4;
  localparam int IDX_W    = 2;

  localparam logic [CHAR_W-1:0]  CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0]  CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_BS = 8'd8;
  localparam logic [GLYPH_W-1:0] CURSOR_GLYPH_RST = 8'd127;

  typedef enum logic [1:0] {
    CMD_ERASE  = 2'd0,
    CMD_DRAW   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_SCROLL = 2'd3
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t           command;
    logic [ROW_W-1:0]    cell_row;
    logic [COL_W-1:0]    cell_col;
    logic [GLYPH_W-1:0]  glyph;
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t [MAX_CMDS-1:0] item;
    logic [IDX_W-1:0]         last_idx;
  } burst_t;

endpackage

### src/ttcc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcc_ifs
// Valid/ready channels: character requests in, cell command requests out.
// ----------------------------------------------------------------------------
interface ttcc_char_if;
  import ttcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ttcc_cmd_if;
  import ttcc_pkg::*;

  logic               valid;
  logic               ready;
  cmd_code_t          command;
  logic [ROW_W-1:0]   cell_row;
  logic [COL_W-1:0]   cell_col;
  logic [GLYPH_W-1:0] glyph;
  logic               last;

  modport source (output valid, output command, output cell_row, output cell_col,
                  output glyph, output last, input ready);
  modport sink   (input valid, input command, input cell_row, input cell_col,
                  input glyph, input last, output ready);
endinterface

### src/text_console_cursor_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_control
// Cursor tracking for a 25x80 text grid: each character request turns into
// two to four cell command requests (erase, draw/clear/scroll, redraw).
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        handshake
//  char_in   in   char_code[7:0]                                 valid/ready
//  cmd_out   out  command, cell_row, cell_col, glyph, last       valid/ready
//  cfg       in   cfg_data[7:0] (cursor glyph)                   cfg_we
//
//  A character sends one command per cycle, while cmd_out is not stalled,
//  through the single command output register.
//  The next character is taken in the cycle its last command is loaded.
//  First command reaches cmd_out via the held list and the output register.
//  rst (synchronous) homes the cursor to row 0, column 0, glyph 127.
//  cmd_out stall holds the output register and, while a list is still being sent,
//  blocks char_in.
// ----------------------------------------------------------------------------
module text_console_cursor_control (
  input  logic                          clk,
  input  logic                          rst,
  ttcc_char_if.sink                     char_in,
  ttcc_cmd_if.source                    cmd_out,
  input  logic                          cfg_we,
  input  logic [ttcc_pkg::GLYPH_W-1:0]  cfg_data
);
  import ttcc_pkg::*;

  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_col;
  logic [GLYPH_W-1:0] cursor_glyph;
  logic [ROW_W-1:0]   row_next;
  logic [COL_W-1:0]   col_next;
  burst_t             plan;
  cell_cmd_t          out_cmd;
  logic               can_load;
  logic               accept;

  assign accept        = char_in.valid && char_in.ready;
  assign char_in.ready = can_load;

  ttcc_plan u_plan (
    .char_code    (char_in.char_code),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col),
    .cursor_glyph (cursor_glyph),
    .burst        (plan),
    .row_next     (row_next),
    .col_next     (col_next)
  );

  ttcc_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .plan      (plan),
    .can_load  (can_load),
    .out_cmd   (out_cmd),
    .out_last  (cmd_out.last),
    .out_valid (cmd_out.valid),
    .out_ready (cmd_out.ready)
  );

  assign cmd_out.command  = out_cmd.command;
  assign cmd_out.cell_row = out_cmd.cell_row;
  assign cmd_out.cell_col = out_cmd.cell_col;
  assign cmd_out.glyph    = out_cmd.glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row   <= '0;
      cursor_col   <= '0;
      cursor_glyph <= CURSOR_GLYPH_RST;
    end else begin
      if (cfg_we) cursor_glyph <= cfg_data;
      if (accept) begin
        cursor_row <= row_next;
        cursor_col <= col_next;
      end
    end
  end

endmodule

### src/ttcc_plan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcc_plan
// Builds the command list for one character and the next cursor position.
// ----------------------------------------------------------------------------
module ttcc_plan (
  input  logic [ttcc_pkg::CHAR_W-1:0]  char_code,
  input  logic [ttcc_pkg::ROW_W-1:0]   cursor_row,
  input  logic [ttcc_pkg::COL_W-1:0]   cursor_col,
  input  logic [ttcc_pkg::GLYPH_W-1:0] cursor_glyph,
  output ttcc_pkg::burst_t             burst,
  output logic [ttcc_pkg::ROW_W-1:0]   row_next,
  output logic [ttcc_pkg::COL_W-1:0]   col_next
);
  import ttcc_pkg::*;

  logic [ROW_W:0]     row_inc;
  logic [COL_W:0]     col_inc;
  logic               at_bottom;
  logic [ROW_W-1:0]   nl_row;
  cell_cmd_t          scroll_cmd;
  cell_cmd_t          erase_cmd;
  cell_cmd_t          final_cmd;
  cell_cmd_t          mid0;
  cell_cmd_t          mid1;
  logic [1:0]         n_mid;

  assign row_inc   = {1'b0, cursor_row} + 1'b1;
  assign col_inc   = {1'b0, cursor_col} + 1'b1;
  assign at_bottom = row_inc >= (ROW_W+1)'(ROWS);
  assign nl_row    = at_bottom ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];

  assign scroll_cmd = '{CMD_SCROLL, ROW_W'(KEEP_TOP_ROWS), '0, '0};
  assign erase_cmd  = '{CMD_ERASE, cursor_row, cursor_col, cursor_glyph};
  assign final_cmd  = '{CMD_DRAW, row_next, col_next, cursor_glyph};

  always_comb begin
    row_next = cursor_row;
    col_next = cursor_col;
    mid0     = '0;
    mid1     = '0;
    n_mid    = 2'd0;
    unique case (char_code)
      CH_CR: begin
        col_next = '0;
      end
      CH_LF: begin
        row_next = nl_row;
        if (at_bottom) begin
          mid0  = scroll_cmd;
          n_mid = 2'd1;
        end
      end
      CH_BS: begin
        if (cursor_col != '0) begin
          col_next = cursor_col - 1'b1;
          mid0     = '{CMD_CLEAR, cursor_row, cursor_col - 1'b1, '0};
          n_mid    = 2'd1;
        end
      end
      default: begin
        mid0  = '{CMD_DRAW, cursor_row, cursor_col, char_code};
        n_mid = 2'd1;
        if (col_inc >= (COL_W+1)'(COLS)) begin
          col_next = '0;
          row_next = nl_row;
          if (at_bottom) begin
            mid1  = scroll_cmd;
            n_mid = 2'd2;
          end
        end else begin
          col_next = col_inc[COL_W-1:0];
        end
      end
    endcase
  end

  always_comb begin
    burst.item[0]  = erase_cmd;
    burst.item[3]  = final_cmd;
    burst.last_idx = IDX_W'(n_mid + 2'd1);
    unique case (n_mid)
      2'd0: begin
        burst.item[1] = final_cmd;
        burst.item[2] = final_cmd;
      end
      2'd1: begin
        burst.item[1] = mid0;
        burst.item[2] = final_cmd;
      end
      default: begin
        burst.item[1] = mid0;
        burst.item[2] = mid1;
      end
    endcase
  end

endmodule

### src/ttcc_burst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcc_burst
// Holds one command list and sends it out one command per cycle through
// an output register while the output is not stalled.
// ----------------------------------------------------------------------------
module ttcc_burst (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ttcc_pkg::burst_t      plan,
  output logic                  can_load,
  output ttcc_pkg::cell_cmd_t   out_cmd,
  output logic                  out_last,
  output logic                  out_valid,
  input  logic                  out_ready
);
  import ttcc_pkg::*;

  burst_t           held;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             out_free;
  logic             step;
  logic             final_step;

  assign out_free   = !out_valid || out_ready;
  assign step       = busy && out_free;
  assign final_step = step && (idx == held.last_idx);
  assign can_load   = !busy || final_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) out_valid <= busy;
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (final_step) begin
        busy <= 1'b0;
      end else if (step) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_cmd  <= held.item[idx];
      out_last <= (idx == held.last_idx);
    end
    if (load) held <= plan;
  end

endmodule

### src/ttcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcc_checker
// Port-level checks on the command output of the cursor control block.
// ----------------------------------------------------------------------------
module ttcc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input ttcc_pkg::cmd_code_t           command,
  input logic [ttcc_pkg::ROW_W-1:0]    cell_row,
  input logic [ttcc_pkg::COL_W-1:0]    cell_col,
  input logic [ttcc_pkg::GLYPH_W-1:0]  glyph,
  input logic                          last
);
  import ttcc_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command) && $stable(cell_row)
      && $stable(cell_col) && $stable(glyph) && $stable(last))
    else $error("command changed while stalled");

  a_in_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_row < ROW_W'(ROWS) && cell_col < COL_W'(COLS))
    else $error("command outside the grid");

  a_scroll_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_SCROLL |->
      cell_row == ROW_W'(KEEP_TOP_ROWS) && cell_col == '0 && glyph == '0 && !last)
    else $error("bad scroll command");

  a_last_is_draw: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> command == CMD_DRAW)
    else $error("final command is not a cursor draw");

  a_first_is_erase: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_ready && last) && out_valid |-> command == CMD_ERASE)
    else $error("list does not open with an erase");

endmodule

bind text_console_cursor_control ttcc_checker u_ttcc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (cmd_out.valid),
  .out_ready (cmd_out.ready),
  .command   (cmd_out.command),
  .cell_row  (cmd_out.cell_row),
  .cell_col  (cmd_out.cell_col),
  .glyph     (cmd_out.glyph),
  .last      (cmd_out.last)
);

### bench/text_console_cursor_control_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_control_test
// Self-checking bench for the cursor control block. Character requests are
// sent in random bursts while the command side stalls on its own pattern.
// A cursor tracker in the bench predicts every cell command request, and
// each command is checked in order, field by field. The run covers control
// characters, column wrap, bottom-row scroll, cursor glyph settings, a long
// output hold-off and random text.
// ----------------------------------------------------------------------------
module text_console_cursor_control_test;
  import ttcc_pkg::*;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_ITEMS     = 12;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_EVERY_THIRD, RX_BURSTY} rx_mode_t;

  typedef struct {
    cmd_code_t          command;
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic [GLYPH_W-1:0] glyph;
    logic               last;
  } cell_req_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [GLYPH_W-1:0] cfg_data;

  ttcc_char_if char_if ();
  ttcc_cmd_if  cmd_if ();

  text_console_cursor_control u_top (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_if),
    .cmd_out (cmd_if),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cursor tracker
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [GLYPH_W-1:0] cur_glyph;
  cell_req_t          expected_cmds[$];

  int       error_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       sender_gaps_on = 1'b1;
  rx_mode_t rx_mode = RX_STEADY;
  logic     long_hold_req = 1'b0;

  function automatic cell_req_t make_cmd(cmd_code_t c, logic [ROW_W-1:0] r,
                                         logic [COL_W-1:0] col, logic [GLYPH_W-1:0] g);
    cell_req_t e;
    e.command  = c;
    e.cell_row = r;
    e.cell_col = col;
    e.glyph    = g;
    e.last     = 1'b0;
    return e;
  endfunction

  // returns 1 when the move past the bottom row needs a scroll
  function automatic bit step_row();
    if (cur_row + 1 >= ROWS) begin
      cur_row = ROW_W'(ROWS - 1);
      return 1'b1;
    end
    cur_row = cur_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_cell_cmds(input logic [CHAR_W-1:0] ch);
    cell_req_t burst[$];
    cell_req_t redraw;
    burst.push_back(make_cmd(CMD_ERASE, cur_row, cur_col, cur_glyph));
    if (ch == CH_CR) begin
      cur_col = '0;
    end else if (ch == CH_LF) begin
      if (step_row())
        burst.push_back(make_cmd(CMD_SCROLL, ROW_W'(KEEP_TOP_ROWS), '0, '0));
    end else if (ch == CH_BS) begin
      if (cur_col != 0) begin
        cur_col = cur_col - 1'b1;
        burst.push_back(make_cmd(CMD_CLEAR, cur_row, cur_col, '0));
      end
    end else begin
      burst.push_back(make_cmd(CMD_DRAW, cur_row, cur_col, ch));
      cur_col = cur_col + 1'b1;
      if (cur_col >= COLS) begin
        cur_col = '0;
        if (step_row())
          burst.push_back(make_cmd(CMD_SCROLL, ROW_W'(KEEP_TOP_ROWS), '0, '0));
      end
    end
    redraw      = make_cmd(CMD_DRAW, cur_row, cur_col, cur_glyph);
    redraw.last = 1'b1;
    foreach (burst[i]) expected_cmds.push_back(burst[i]);
    expected_cmds.push_back(redraw);
  endfunction

  function automatic logic [CHAR_W-1:0] printable_byte();
    logic [CHAR_W-1:0] b;
    do b = CHAR_W'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF || b == CH_BS);
    return b;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // sends one character request; valid stays high while the burst goes on
  task automatic send_char(input logic [CHAR_W-1:0] ch);
    int gap;
    char_if.valid     <= 1'b1;
    char_if.char_code <= ch;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    predict_cell_cmds(ch);
    if (sender_gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap        = $urandom_range(0, 5);
        if (gap > 0) begin
          char_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic wait_idle();
    char_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cursor_glyph(input logic [GLYPH_W-1:0] g);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_glyph  = g;
  endtask

  task automatic test_control_chars();
    rx_mode = RX_STEADY;
    send_char(CH_BS);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h41);
    send_char(CH_BS);
    send_char(CH_CR);
    send_char(CH_LF);
    rx_mode = RX_EVERY_THIRD;
    send_char(8'h07);
    send_char(8'h09);
    send_char(8'h0B);
    send_char(8'h0C);
    send_char(8'h0E);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(CH_CR);
    send_char(CH_BS);
    send_char(CH_LF);
    send_char(8'h55);
    send_char(8'hAA);
  endtask

  task automatic test_cursor_glyph();
    rx_mode = RX_RANDOM;
    set_cursor_glyph(8'h00);
    send_char(8'h31);
    send_char(CH_BS);
    send_char(CH_LF);
    set_cursor_glyph(8'hFF);
    send_char(8'h32);
    send_char(CH_CR);
    set_cursor_glyph(8'hA5);
    send_char(8'h33);
    set_cursor_glyph(8'h5A);
    send_char(CH_BS);
    send_char(8'h34);
  endtask

  // line feeds down to the bottom row and past it, then text up to the end of
  // the row that wraps and scrolls on the bottom row
  task automatic test_wrap_and_scroll();
    rx_mode = RX_RANDOM;
    repeat (ROWS) send_char(CH_LF);
    rx_mode = RX_BURSTY;
    repeat (COLS - cur_col) send_char(printable_byte());
    send_char(CH_BS);
    rx_mode = RX_STEADY;
    send_char(8'h21);
    send_char(CH_BS);
    wait_idle();
  endtask

  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    rx_mode        = RX_STEADY;
    long_hold_req <= 1'b1;
    repeat (8) send_char(printable_byte());
    send_char(CH_LF);
    send_char(CH_BS);
    sender_gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_text();
    int sent;
    int len;
    int room;
    int next_cfg;
    sent     = 0;
    next_cfg = 40;
    while (sent < RANDOM_ITEMS) begin
      rx_mode        = rx_mode_t'($urandom_range(0, 3));
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        room = COLS - cur_col;
        len  = $urandom_range(room - 1, room + 2);
      end else begin
        len = $urandom_range(0, 12);
      end
      repeat (len) begin
        if ($urandom_range(0, 11) == 0) send_char(CH_BS);
        else if ($urandom_range(0, 19) == 0) send_char(CHAR_W'($urandom_range(0, 255)));
        else send_char(printable_byte());
        sent++;
      end
      case ($urandom_range(0, 3))
        0: begin
          send_char(CH_CR);
          send_char(CH_LF);
          sent += 2;
        end
        1: begin
          send_char(CH_LF);
          sent++;
        end
        2: begin
          send_char(CH_CR);
          sent++;
        end
        default: ;
      endcase
      if (sent >= next_cfg) begin
        set_cursor_glyph(GLYPH_W'($urandom_range(0, 255)));
        next_cfg += 40;
      end
    end
  endtask

  // command side ready pattern, with a long hold-off on request
  initial begin : receiver
    int stall_left;
    int phase;
    stall_left = 0;
    phase      = 0;
    cmd_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        cmd_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req <= 1'b0;
      end else begin
        phase = (phase + 1) % 3;
        case (rx_mode)
          RX_STEADY:      cmd_if.ready <= 1'b1;
          RX_RANDOM:      cmd_if.ready <= ($urandom_range(0, 3) != 0);
          RX_EVERY_THIRD: cmd_if.ready <= (phase != 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              cmd_if.ready <= 1'b0;
            end else begin
              cmd_if.ready <= 1'b1;
              if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 8);
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    cell_req_t want;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected cell command, expected none, actual cmd %0d row %0d col %0d",
                 $time, cmd_if.command, cmd_if.cell_row, cmd_if.cell_col);
        error_count++;
      end else begin
        want = expected_cmds.pop_front();
        compare_field("command", want.command, cmd_if.command);
        compare_field("cell_row", want.cell_row, cmd_if.cell_row);
        compare_field("cell_col", want.cell_col, cmd_if.cell_col);
        compare_field("glyph", want.glyph, cmd_if.glyph);
        compare_field("last", want.last, cmd_if.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst               <= 1'b1;
    char_if.valid     <= 1'b0;
    char_if.char_code <= '0;
    cfg_we            <= 1'b0;
    cfg_data          <= '0;
    cur_row            = '0;
    cur_col            = '0;
    cur_glyph          = CURSOR_GLYPH_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_control_chars();
    test_cursor_glyph();
    test_wrap_and_scroll();
    test_backpressure();
    test_random_text();
    wait_idle();

    if (error_count == 0 && expected_cmds.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
